// ===== sv/bba_pkg.sv =====
package bba_pkg;

   localparam int NUM_BLOCKS  = 4096;
   localparam int WORD_BITS   = 32;
   localparam int NUM_WORDS   = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int BLK_W       = $clog2(NUM_BLOCKS);
   localparam int BIT_W       = $clog2(WORD_BITS);
   localparam int WADDR_W     = $clog2(NUM_WORDS);
   localparam int TOTAL_W     = BLK_W + 1;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;

   // register index, taken from paddr[2]
   localparam logic REG_TOTAL_BLOCKS = 1'b0;

   typedef enum logic [1:0] {
      ACT_QUERY = 2'd0,
      ACT_FREE  = 2'd1,
      ACT_ALLOC = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_NOSPACE = 2'd1,
      STAT_ZERO    = 2'd2,
      STAT_RANGE   = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]       action;
      logic [BLK_W-1:0] block_number;
   } req_type;

   typedef struct packed {
      logic             is_free;
      logic [BLK_W-1:0] allocated_block;
      status_type       status;
   } rsp_type;

endpackage

// ===== sv/bitmap_block_allocator_unit.sv =====
// first-fit free-block bitmap allocator, one bit per block, 1 means free
// req channel (valid/ready): a word carries an action (query, free, allocate)
//   and a block number; req_ready is high only while the unit is idle
// rsp channel (valid/ready): one word per request with is_free, allocated_block
//   and status; the result sits in an output register, so the unit goes back
//   to idle and takes the next request while that result waits
// apb port: total_blocks at address 0, written on the access cycle
// query reads the block's bitmap word once; free reads it and then writes it back;
//   allocate scans from word 0 up to the word holding the first free block, or
//   through the last managed word when nothing is free; the scan reads one
//   bitmap word per cycle from a single-port-read ram
// rejected requests (block out of range, free of block zero, no blocks
//   managed, unknown action) answer without touching the bitmap
// reset: all blocks in use, total_blocks 0; per-word valid flags make unwritten
//   bitmap words read as zero, so no clearing pass is needed
// if the receiver stalls, a finished result waits in the unit until the
//   output register frees up, and no new request is taken meanwhile
module bitmap_block_allocator_unit
   import bba_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_LOOK = 4'b0010,
      ST_SCAN = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   function automatic logic [BIT_W-1:0] bit_index(input logic [WORD_BITS-1:0] onehot);
      logic [BIT_W-1:0] idx;
      idx = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (onehot[i]) begin
            idx = idx | BIT_W'(i);
         end
      end
      return idx;
   endfunction

   state_type              state_ff, state_in;
   logic [1:0]             act_ff, act_in;
   logic [BLK_W-1:0]       blk_ff, blk_in;
   logic [WADDR_W-1:0]     chk_ff, chk_in;
   logic [WADDR_W-1:0]     last_word_ff, last_word_in;
   logic [WORD_BITS-1:0]   last_mask_ff, last_mask_in;
   rsp_type                res_ff, res_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;
   logic [TOTAL_W-1:0]     total_ff, total_in;
   logic [NUM_WORDS-1:0]   valid_ff, valid_in;
   logic                   valid_rd_ff;

   logic [TOTAL_W-1:0]     lim;
   logic [TOTAL_W-1:0]     lim_m1;
   logic                   req_fire;
   logic                   csr_wr;
   logic                   wr_en;
   logic [WADDR_W-1:0]     wr_addr;
   logic [WORD_BITS-1:0]   wr_data;
   logic [WADDR_W-1:0]     rd_addr;
   logic [WORD_BITS-1:0]   rd_data;
   logic [WORD_BITS-1:0]   word_data;
   logic [WORD_BITS-1:0]   scan_bits;
   logic [WORD_BITS-1:0]   hit_onehot;
   logic [BIT_W-1:0]       hit_idx;

   bba_ram #(
      .WIDTH(WORD_BITS),
      .DEPTH(NUM_WORDS)
   ) u_bitmap (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // config port
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready && (paddr[2] == REG_TOTAL_BLOCKS);
   assign prdata = (paddr[2] == REG_TOTAL_BLOCKS) ? CSR_DATA_W'(total_ff) : '0;
   assign total_in = csr_wr ? pwdata[TOTAL_W-1:0] : total_ff;

   assign lim    = (total_ff > TOTAL_W'(NUM_BLOCKS)) ? TOTAL_W'(NUM_BLOCKS) : total_ff;
   assign lim_m1 = lim - TOTAL_W'(1);

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // never-written words read as all in use
   assign word_data  = rd_data & {WORD_BITS{valid_rd_ff}};
   // blocks past the total in the last word are never handed out
   assign scan_bits  = word_data & ((chk_ff == last_word_ff) ? last_mask_ff : '1);
   assign hit_onehot = scan_bits & (~scan_bits + WORD_BITS'(1));
   assign hit_idx    = bit_index(hit_onehot);

   always_comb begin
      state_in     = state_ff;
      act_in       = act_ff;
      blk_in       = blk_ff;
      chk_in       = chk_ff;
      last_word_in = last_word_ff;
      last_mask_in = last_mask_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      valid_in     = valid_ff;
      wr_en        = 1'b0;
      wr_addr      = blk_ff[BLK_W-1:BIT_W];
      wr_data      = word_data;
      rd_addr      = chk_ff + WADDR_W'(1);

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            rd_addr = (req_data.action == ACT_ALLOC) ? '0
                                                     : req_data.block_number[BLK_W-1:BIT_W];
            if (req_fire) begin
               act_in       = req_data.action;
               blk_in       = req_data.block_number;
               chk_in       = '0;
               last_word_in = lim_m1[BLK_W-1:BIT_W];
               last_mask_in = {WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - lim_m1[BIT_W-1:0]);
               res_in       = '0;
               state_in     = ST_DONE;
               case (req_data.action)
                  ACT_QUERY: begin
                     if ({1'b0, req_data.block_number} < lim) begin
                        state_in = ST_LOOK;
                     end
                  end
                  ACT_FREE: begin
                     if (req_data.block_number == '0) begin
                        res_in.status = STAT_ZERO;
                     end else if ({1'b0, req_data.block_number} >= lim) begin
                        res_in.status = STAT_RANGE;
                     end else begin
                        state_in = ST_LOOK;
                     end
                  end
                  ACT_ALLOC: begin
                     if (lim == '0) begin
                        res_in.status = STAT_NOSPACE;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  default: begin
                     res_in = '0;
                  end
               endcase
            end
         end
         ST_LOOK: begin
            if (act_ff == ACT_QUERY) begin
               res_in.is_free = word_data[blk_ff[BIT_W-1:0]];
            end else begin
               wr_en   = 1'b1;
               wr_data = word_data | (WORD_BITS'(1) << blk_ff[BIT_W-1:0]);
            end
            state_in = ST_DONE;
         end
         ST_SCAN: begin
            if (|scan_bits) begin
               wr_en                  = 1'b1;
               wr_addr                = chk_ff;
               wr_data                = word_data & ~hit_onehot;
               res_in.allocated_block = {chk_ff, hit_idx};
               res_in.status          = STAT_OK;
               state_in               = ST_DONE;
            end else if (chk_ff == last_word_ff) begin
               res_in.status = STAT_NOSPACE;
               state_in      = ST_DONE;
            end else begin
               chk_in = chk_ff + WADDR_W'(1);
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         total_ff     <= '0;
         valid_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         total_ff     <= total_in;
         valid_ff     <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff       <= act_in;
      blk_ff       <= blk_in;
      chk_ff       <= chk_in;
      last_word_ff <= last_word_in;
      last_mask_ff <= last_mask_in;
      res_ff       <= res_in;
      rsp_data_ff  <= rsp_data_in;
      valid_rd_ff  <= valid_ff[rd_addr];
   end

`ifndef SYNTH
   // bitmap is only written while a lookup or scan resolves
   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_LOOK || state_ff == ST_SCAN))
      else $error("bitmap write outside lookup or scan");

   // one request in flight at a time
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("request taken while busy");

   // a block number only accompanies a successful allocate
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status != STAT_OK) |-> (rsp_data_ff.allocated_block == '0))
      else $error("allocated block on failed request");

   // a finished result is moved out only when the output register is free
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_valid_ff && !rsp_ready) |=> (state_ff == ST_DONE))
      else $error("result dropped under stall");
`endif

endmodule

// ===== sv/bba_ram.sv =====
module bba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
